### design/rtbe_pkg.sv
// rtbe_pkg: shared constants, command codes and the header byte lookup
// for the RGBA to 24-bit BMP stream encoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rtbe_pkg;

    // Request command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int CFG_W = 13;

    localparam int         HDR_BYTES  = 54;
    localparam int         IDX_W      = 6;
    localparam logic [5:0] HDR_LAST   = 6'(HDR_BYTES - 1);
    localparam logic [7:0] INFO_BYTES = 8'd40;
    localparam logic [7:0] BPP        = 8'd24;
    localparam logic [7:0] PLANES     = 8'd1;
    localparam logic [7:0] KEY_RB     = 8'hFF;
    localparam logic [7:0] CHAR_B     = 8'h42;
    localparam logic [7:0] CHAR_M     = 8'h4D;

    // One byte of the 54-byte header, little endian multi-byte fields.
    function automatic logic [7:0] hdr_byte(
        input logic [5:0]  idx,
        input logic [31:0] fsize,
        input logic [31:0] w,
        input logic [31:0] h
    );
        logic [7:0] b;
        b = 8'h00;
        unique case (idx)
            6'd0:  b = CHAR_B;
            6'd1:  b = CHAR_M;
            6'd2:  b = fsize[7:0];
            6'd3:  b = fsize[15:8];
            6'd4:  b = fsize[23:16];
            6'd5:  b = fsize[31:24];
            6'd10: b = 8'(HDR_BYTES);
            6'd14: b = INFO_BYTES;
            6'd18: b = w[7:0];
            6'd19: b = w[15:8];
            6'd20: b = w[23:16];
            6'd21: b = w[31:24];
            6'd22: b = h[7:0];
            6'd23: b = h[15:8];
            6'd24: b = h[23:16];
            6'd25: b = h[31:24];
            6'd26: b = PLANES;
            6'd28: b = BPP;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### design/rgba_to_bmp24_stream_encoder.sv
// rgba_to_bmp24_stream_encoder: top level, RGBA pixels to a 24-bit BMP byte stream.
// Depends on rtbe_pkg (command codes, register indexes, header byte lookup).
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------------
// s_       | in        | s_valid / s_ready  | s_command, s_red, s_green, s_blue, s_alpha
// m_       | out       | m_valid / m_ready  | m_out_byte, m_run_last, m_frame_end
// cfg_     | in        | cfg_we (no wait)   | cfg_index, cfg_data
//
// One output byte per cycle while m_ready is high. A pixel request gives 3 bytes, plus
//   (width mod 4) pad bytes at the end of a row; a start request gives 54.
//   The single byte lane of the output register sets this rate.
// A new request is taken in the cycle the previous one's last byte moves
//   into the output register, so bursts run back to back with no bubble.
// Reset (aresetn low, synchronous) empties both stages, zeroes the row and
//   column counters and sets both dimension registers to 1.
// m_ready low holds the output register; the request register then fills
//   and s_ready drops until the output drains.
// Header size field comes from a two-stage register pipe off the dimension
//   registers; it is settled well before header byte 2 is sent.

module rgba_to_bmp24_stream_encoder #(
    parameter int MAX_DIM = 4096
) (
    input  wire        aclk,
    input  wire        aresetn,

    input  wire        s_valid,
    output logic       s_ready,
    input  wire        s_command,
    input  wire [7:0]  s_red,
    input  wire [7:0]  s_green,
    input  wire [7:0]  s_blue,
    input  wire [7:0]  s_alpha,

    output logic       m_valid,
    input  wire        m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_run_last,
    output logic       m_frame_end,

    input  wire        cfg_we,
    input  wire        cfg_index,
    input  wire [rtbe_pkg::CFG_W-1:0] cfg_data
);

    // Dimension widths follow MAX_DIM; at least 2 bits for the pad select
    localparam int DIM_W = ($clog2(MAX_DIM + 1) > 2) ? $clog2(MAX_DIM + 1) : 2;
    localparam int CMP_W = (DIM_W > rtbe_pkg::CFG_W) ? DIM_W : rtbe_pkg::CFG_W;
    localparam int RB_W  = DIM_W + 2;          // 3*w + pad < 4*(MAX_DIM+1)
    localparam int FS_W  = RB_W + DIM_W + 1;   // product plus header offset

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [rtbe_pkg::CFG_W-1:0] cfg_w_reg, cfg_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= rtbe_pkg::CFG_W'(1);
            cfg_h_reg <= rtbe_pkg::CFG_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_index)
                rtbe_pkg::REG_WIDTH:  cfg_w_reg <= cfg_data;
                rtbe_pkg::REG_HEIGHT: cfg_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective dimensions: 0 reads as 1, anything above MAX_DIM clamps
    logic [DIM_W-1:0] eff_w, eff_h;

    always_comb begin
        if (cfg_w_reg == '0)
            eff_w = DIM_W'(1);
        else if (CMP_W'(cfg_w_reg) > CMP_W'(MAX_DIM))
            eff_w = DIM_W'(MAX_DIM);
        else
            eff_w = DIM_W'(cfg_w_reg);

        if (cfg_h_reg == '0)
            eff_h = DIM_W'(1);
        else if (CMP_W'(cfg_h_reg) > CMP_W'(MAX_DIM))
            eff_h = DIM_W'(MAX_DIM);
        else
            eff_h = DIM_W'(cfg_h_reg);
    end

    // Row pad to a multiple of 4 bytes: (4 - 3w mod 4) mod 4 == w mod 4
    logic [1:0] pad_now;
    assign pad_now = eff_w[1:0];

    // Header field pipe: row bytes and dims, then file size
    logic [DIM_W-1:0] hw_reg, hh_reg;
    logic [RB_W-1:0]  rowb_reg;
    logic [31:0]      fsize_reg;
    logic [FS_W-1:0]  fsize_full;

    assign fsize_full = FS_W'(rtbe_pkg::HDR_BYTES) + FS_W'(rowb_reg) * FS_W'(hh_reg);

    always_ff @(posedge aclk) begin
        hw_reg    <= eff_w;
        hh_reg    <= eff_h;
        rowb_reg  <= RB_W'({eff_w, 1'b0}) + RB_W'(eff_w) + RB_W'(pad_now);
        fsize_reg <= 32'(fsize_full);   // low 32 bits on overflow
    end

    // ------------------------------------------------------------------
    // Row / column tracking, updated as a request is taken
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] col_reg, row_reg;
    logic             row_done, frame_done;

    assign row_done   = ({1'b0, col_reg} + (DIM_W+1)'(1)) >= {1'b0, eff_w};
    assign frame_done = row_done &&
                        (({1'b0, row_reg} + (DIM_W+1)'(1)) >= {1'b0, eff_h});

    // ------------------------------------------------------------------
    // Request register: one request being serialized
    // ------------------------------------------------------------------
    logic                      item_valid_reg;
    logic                      item_cmd_reg;
    logic [7:0]                item_b_reg, item_g_reg, item_r_reg;
    logic [1:0]                item_pad_reg;
    logic                      item_fend_reg;
    logic [rtbe_pkg::IDX_W-1:0] item_idx_reg;

    logic                      out_free, item_last, item_move, s_take;
    logic [rtbe_pkg::IDX_W-1:0] last_idx;
    logic [7:0]                byte_now;

    assign last_idx  = (item_cmd_reg == rtbe_pkg::CMD_START) ? rtbe_pkg::HDR_LAST
                     : rtbe_pkg::IDX_W'(2) + rtbe_pkg::IDX_W'(item_pad_reg);
    assign item_last = (item_idx_reg == last_idx);
    assign out_free  = !m_valid || m_ready;
    assign item_move = item_valid_reg && out_free;
    assign s_ready   = !item_valid_reg || (out_free && item_last);
    assign s_take    = s_valid && s_ready;

    // Byte selected from the current request
    always_comb begin
        if (item_cmd_reg == rtbe_pkg::CMD_START) begin
            byte_now = rtbe_pkg::hdr_byte(item_idx_reg, fsize_reg,
                                          32'(hw_reg), 32'(hh_reg));
        end else begin
            case (item_idx_reg)
                rtbe_pkg::IDX_W'(0): byte_now = item_b_reg;
                rtbe_pkg::IDX_W'(1): byte_now = item_g_reg;
                rtbe_pkg::IDX_W'(2): byte_now = item_r_reg;
                default:             byte_now = 8'h00;    // row padding
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            item_idx_reg   <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
        end else begin
            if (s_take) begin
                item_valid_reg <= 1'b1;
                item_idx_reg   <= '0;
            end else if (item_move) begin
                if (item_last)
                    item_valid_reg <= 1'b0;
                item_idx_reg <= item_idx_reg + rtbe_pkg::IDX_W'(1);
            end

            if (s_take) begin
                if (s_command == rtbe_pkg::CMD_START) begin
                    col_reg <= '0;
                    row_reg <= '0;
                end else if (row_done) begin
                    col_reg <= '0;
                    row_reg <= frame_done ? '0 : row_reg + DIM_W'(1);
                end else begin
                    col_reg <= col_reg + DIM_W'(1);
                end
            end
        end
    end

    // Request payload; alpha zero swaps in the magenta key
    always_ff @(posedge aclk) begin
        if (s_take) begin
            item_cmd_reg  <= s_command;
            item_pad_reg  <= row_done ? pad_now : 2'd0;
            item_fend_reg <= (s_command == rtbe_pkg::CMD_PIXEL) && frame_done;
            if (s_alpha == 8'h00) begin
                item_b_reg <= rtbe_pkg::KEY_RB;
                item_g_reg <= 8'h00;
                item_r_reg <= rtbe_pkg::KEY_RB;
            end else begin
                item_b_reg <= s_blue;
                item_g_reg <= s_green;
                item_r_reg <= s_red;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_free) begin
            m_valid <= item_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_move) begin
            m_out_byte  <= byte_now;
            m_run_last  <= item_last;
            m_frame_end <= item_last && item_fend_reg;
        end
    end

endmodule

`default_nettype wire

### design/rtbe_checker.sv
// rtbe_checker: port-level checks for rgba_to_bmp24_stream_encoder, plus its bind.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
`default_nettype none

module rtbe_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_ready,
    input wire       m_valid,
    input wire       m_ready,
    input wire [7:0] m_out_byte,
    input wire       m_run_last,
    input wire       m_frame_end
);

    // Stalled output byte holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) &&
                                $stable(m_run_last) && $stable(m_frame_end))
        else $error("output byte changed while stalled");

    // Frame end only ever marks the last byte of a request
    a_fend_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_run_last)
        else $error("frame_end without run_last");

    // A burst streams without gaps once the consumer takes bytes
    a_burst_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> m_valid)
        else $error("gap inside a request burst");

    // Reset empties the output and opens the input
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("state not cleared by reset");

endmodule

bind rgba_to_bmp24_stream_encoder rtbe_checker u_rtbe_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_byte  (m_out_byte),
    .m_run_last  (m_run_last),
    .m_frame_end (m_frame_end)
);

`default_nettype wire
